### hdl/sksel_pkg.sv
// Shared types and constants for the streaming k-smallest selection block.
`timescale 1ns / 1ps

package sksel_pkg;

  // Fixed field widths of the stream words and the register port
  localparam int KEEP_COUNT_W  = 6;
  localparam int VALUE_FIELD_W = 32;
  localparam int INDEX_FIELD_W = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 6;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_COUNT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_VALUES = 1'd1;

  // Register reset values
  localparam logic [KEEP_COUNT_W-1:0] KEEP_COUNT_RESET    = 6'd8;
  localparam logic                    SIGNED_VALUES_RESET = 1'b1;

  // Input word
  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] in_value;
    logic                     in_last;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] out_value;
    logic [INDEX_FIELD_W-1:0] out_index;
    logic                     out_last;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // capture the input word
    logic append;      // write the item into the next free entry
    logic scan_start;  // restart the entry scan
    logic scan_run;    // step the entry scan
    logic scan_min;    // scan looks for the smallest untaken entry, else the largest
    logic replace;     // overwrite the largest entry if the item is smaller
    logic emit;        // load the output register with the scan winner
    logic finish;      // clear held entries and the position counter
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic can_append;   // a free slot below the keep count exists
    logic scan_done;    // scan has seen every held entry
    logic out_free;     // output register can take a word this cycle
    logic last_result;  // the next emitted word closes the run
    logic item_last;    // captured item carries the last mark
  } dp_status_t;

endpackage

### hdl/sksel_ctrl.sv
// Controller state machine that sequences append, replacement and result selection.
`timescale 1ns / 1ps

module sksel_ctrl
  import sksel_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       in_stall
);

  typedef enum logic [2:0] {
    IDLE,
    APPEND,
    MAX_INIT,
    MAX_SCAN,
    REPLACE,
    SEL_INIT,
    SEL_SCAN,
    EMIT
  } state_t;

  state_t state;
  logic   busy;

  // Decode commands from the current state
  always_comb begin
    cmd            = '0;
    cmd.accept     = (state == IDLE) && in_valid && !busy;
    cmd.append     = (state == APPEND);
    cmd.scan_start = (state == MAX_INIT) || (state == SEL_INIT);
    cmd.scan_run   = (state == MAX_SCAN) || (state == SEL_SCAN);
    cmd.scan_min   = (state == SEL_INIT) || (state == SEL_SCAN);
    cmd.replace    = (state == REPLACE);
    cmd.emit       = (state == EMIT) && status.out_free;
    cmd.finish     = (state == EMIT) && status.out_free && status.last_result;
  end

  assign in_stall = busy;

  // Advance state; hold off the input while an item is in work
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.accept) begin
            busy  <= 1'b1;
            state <= status.can_append ? APPEND : MAX_INIT;
          end
        end
        APPEND: begin
          if (status.item_last) begin
            state <= SEL_INIT;
          end else begin
            state <= IDLE;
            busy  <= 1'b0;
          end
        end
        MAX_INIT: begin
          state <= MAX_SCAN;
        end
        MAX_SCAN: begin
          if (status.scan_done) begin
            state <= REPLACE;
          end
        end
        REPLACE: begin
          if (status.item_last) begin
            state <= SEL_INIT;
          end else begin
            state <= IDLE;
            busy  <= 1'b0;
          end
        end
        SEL_INIT: begin
          state <= SEL_SCAN;
        end
        SEL_SCAN: begin
          if (status.scan_done) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (status.out_free) begin
            if (status.last_result) begin
              state <= IDLE;
              busy  <= 1'b0;
            end else begin
              state <= SEL_INIT;
            end
          end
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hdl/sksel_datapath.sv
// Datapath: entry memory, scan unit, position counter and output register.
`timescale 1ns / 1ps

module sksel_datapath
  import sksel_pkg::*;
#(
  parameter int MAX_KEEP    = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [KEEP_COUNT_W-1:0] keep_count,
  input  logic                    signed_values,
  input  in_word_t                in_data,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic                    out_stall,
  output logic                    out_valid,
  output out_word_t               out_data
);

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // Entry memory
  logic [VALUE_WIDTH-1:0] kept_values    [MAX_KEEP];
  logic [INDEX_WIDTH-1:0] kept_positions [MAX_KEEP];

  // Stream state
  logic [CW-1:0]          fill;
  logic [INDEX_WIDTH-1:0] stream_pos;

  // Captured item
  logic [VALUE_WIDTH-1:0] item_value;
  logic [INDEX_WIDTH-1:0] item_pos;
  logic                   item_last;

  // Scan unit
  logic [CW-1:0]          rd_ptr;
  logic                   rd_vld;
  logic [AW-1:0]          rd_idx;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [INDEX_WIDTH-1:0] rd_pos;
  logic                   best_vld;
  logic [AW-1:0]          best_idx;
  logic [VALUE_WIDTH-1:0] best_val;
  logic [INDEX_WIDTH-1:0] best_pos;

  // Result selection
  logic [MAX_KEEP-1:0]    taken;
  logic [CW-1:0]          emit_cnt;

  logic [CW-1:0]          eff_keep;
  logic [CW-1:0]          emit_total;
  logic                   issue;
  logic                   take_cand;
  logic                   cand_lt_best;
  logic                   best_lt_cand;
  logic                   item_lt_best;
  logic [VALUE_WIDTH-1:0] rd_key;
  logic [VALUE_WIDTH-1:0] best_key;
  logic [VALUE_WIDTH-1:0] item_key;
  logic [VALUE_WIDTH+VALUE_FIELD_W-1:0] in_ext;
  logic [VALUE_WIDTH+VALUE_FIELD_W-1:0] out_val_ext;
  logic [INDEX_WIDTH+INDEX_FIELD_W-1:0] out_pos_ext;

  // Map a value onto an unsigned order key
  function automatic logic [VALUE_WIDTH-1:0] order_key(input logic [VALUE_WIDTH-1:0] v,
                                                       input logic sgn);
    logic [VALUE_WIDTH-1:0] k;
    k = v;
    k[VALUE_WIDTH-1] = v[VALUE_WIDTH-1] ^ sgn;
    return k;
  endfunction

  // Clamp the keep count into 1..MAX_KEEP
  always_comb begin
    if (keep_count == '0) begin
      eff_keep = CW'(1);
    end else if (int'(keep_count) > MAX_KEEP) begin
      eff_keep = CW'(MAX_KEEP);
    end else begin
      eff_keep = CW'(keep_count);
    end
  end

  assign emit_total = (fill < eff_keep) ? fill : eff_keep;

  // Width adaption between stream fields and internal storage
  assign in_ext      = {{VALUE_WIDTH{1'b0}}, in_data.in_value};
  assign out_val_ext = {{VALUE_FIELD_W{1'b0}}, best_val};
  assign out_pos_ext = {{INDEX_FIELD_W{1'b0}}, best_pos};

  // Compare the candidate read from memory against the running winner
  assign rd_key       = order_key(rd_val, signed_values);
  assign best_key     = order_key(best_val, signed_values);
  assign item_key     = order_key(item_value, signed_values);
  assign cand_lt_best = (rd_key < best_key) || ((rd_key == best_key) && (rd_pos < best_pos));
  assign best_lt_cand = (best_key < rd_key) || ((rd_key == best_key) && (best_pos < rd_pos));
  assign item_lt_best = item_key < best_key;

  always_comb begin
    if (cmd.scan_min) begin
      take_cand = !taken[rd_idx] && (!best_vld || cand_lt_best);
    end else begin
      take_cand = !best_vld || best_lt_cand;
    end
  end

  assign issue = cmd.scan_run && (rd_ptr < fill);

  // Status to the controller
  always_comb begin
    status             = '0;
    status.can_append  = (fill < eff_keep) && (fill < CW'(MAX_KEEP));
    status.scan_done   = cmd.scan_run && (rd_ptr == fill) && !rd_vld;
    status.out_free    = !out_valid || !out_stall;
    status.last_result = ({1'b0, emit_cnt} + (CW + 1)'(1)) == {1'b0, emit_total};
    status.item_last   = item_last;
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_value <= in_ext[VALUE_WIDTH-1:0];
      item_last  <= in_data.in_last;
      item_pos   <= stream_pos;
    end
  end

  // Write the entry memory and read one entry per scan step
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      kept_values[fill[AW-1:0]]    <= item_value;
      kept_positions[fill[AW-1:0]] <= item_pos;
    end else if (cmd.replace && item_lt_best) begin
      kept_values[best_idx]    <= item_value;
      kept_positions[best_idx] <= item_pos;
    end
    if (issue) begin
      rd_val <= kept_values[rd_ptr[AW-1:0]];
      rd_pos <= kept_positions[rd_ptr[AW-1:0]];
      rd_idx <= rd_ptr[AW-1:0];
    end
  end

  // Fill count and saturating stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      stream_pos <= '0;
    end else if (cmd.finish) begin
      fill       <= '0;
      stream_pos <= '0;
    end else begin
      if (cmd.append) begin
        fill <= fill + CW'(1);
      end
      if ((cmd.append || cmd.replace) && (stream_pos != '1)) begin
        stream_pos <= stream_pos + INDEX_WIDTH'(1);
      end
    end
  end

  // Scan pointer and running winner
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      rd_vld   <= 1'b0;
      best_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_ptr   <= '0;
      rd_vld   <= 1'b0;
      best_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
      if (cmd.scan_run && rd_vld && take_cand) begin
        best_vld <= 1'b1;
        best_idx <= rd_idx;
        best_val <= rd_val;
        best_pos <= rd_pos;
      end
    end
  end

  // Track emitted entries for the current run
  always_ff @(posedge clk) begin
    if (rst) begin
      taken    <= '0;
      emit_cnt <= '0;
    end else if (cmd.accept) begin
      taken    <= '0;
      emit_cnt <= '0;
    end else if (cmd.emit) begin
      taken[best_idx] <= 1'b1;
      emit_cnt        <= emit_cnt + CW'(1);
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.out_value <= out_val_ext[VALUE_FIELD_W-1:0];
      out_data.out_index <= out_pos_ext[INDEX_FIELD_W-1:0];
      out_data.out_last  <= status.last_result;
    end
  end

endmodule

### hdl/streaming_k_smallest_select.sv
// Top level of the streaming k-smallest selection block: registers, controller, datapath.
`timescale 1ns / 1ps

// Keeps the keep_count smallest values of a stream with their positions and, on the
// word marked last, sends them out in ascending order (ties by position), then clears.
// One item is in work at a time. An item that fills a free slot is written in the
// APPEND state. Once keep_count entries are held, the largest entry is found for each
// item by reading every held entry through the single read port of the entry memory.
// A last item then adds one pass over the held entries per result, each pass looking
// for the smallest one not yet sent. The output register decouples the result side;
// a stalled result holds its slot but not the next stream once the final result is
// loaded. No clearing pass follows reset.
module streaming_k_smallest_select
  import sksel_pkg::*;
#(
  parameter int MAX_KEEP    = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_data
);

  logic [KEEP_COUNT_W-1:0] keep_count;
  logic                    signed_values;
  dp_cmd_t                 cmd;
  dp_status_t              status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count    <= KEEP_COUNT_RESET;
      signed_values <= SIGNED_VALUES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEEP_COUNT:    keep_count    <= cfg_data[KEEP_COUNT_W-1:0];
        REG_SIGNED_VALUES: signed_values <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sksel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  sksel_datapath #(
    .MAX_KEEP    (MAX_KEEP),
    .VALUE_WIDTH (VALUE_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .keep_count    (keep_count),
    .signed_values (signed_values),
    .in_data       (in_data),
    .cmd           (cmd),
    .status        (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

  // An accepted word keeps the input stalled while it is in work
  assert property (@(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // A pending result that is not the last one means the block is still busy
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_data.out_last) |-> in_stall)
    else $error("input open while a run still has results to send");

  // A stalled result word holds until it is taken
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed or dropped");

  // Results only appear while a run is being sent out
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while the block was idle");

endmodule

### tb/testbench.sv
// Self-checking testbench for the streaming k-smallest selection block.
`timescale 1ns / 1ps

module testbench;
  import sksel_pkg::*;

  localparam int KEEP_LIMIT = 32;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_word_t              out_data;

  streaming_k_smallest_select u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Mirror of the register settings and the held entries
  logic [5:0]  keep_reg   = KEEP_COUNT_RESET;
  logic        signed_reg = SIGNED_VALUES_RESET;
  logic [31:0] kept_val [KEEP_LIMIT];
  logic [15:0] kept_pos [KEEP_LIMIT];
  int          kept_n     = 0;
  logic [15:0] next_pos   = '0;
  out_word_t   pending_results [$];

  int errors  = 0;
  bit idle_on = 1'b1;
  int hold_req = 0;

  // Map a value to an unsigned sort key under the current signedness
  function automatic logic [31:0] rank_key(input logic [31:0] v);
    return signed_reg ? (v ^ 32'h8000_0000) : v;
  endfunction

  // True when entry a sorts strictly ahead of entry b
  function automatic bit ranks_before(input logic [31:0] va, input logic [15:0] pa,
                                      input logic [31:0] vb, input logic [15:0] pb);
    if (rank_key(va) != rank_key(vb))
      return rank_key(va) < rank_key(vb);
    return pa < pb;
  endfunction

  // Fold one accepted word into the held set; queue the sorted results on a last word
  task automatic select_accept(input logic [31:0] v, input logic is_last);
    int          k;
    int          top;
    int          n;
    int          i;
    int          j;
    logic [31:0] sort_val [KEEP_LIMIT];
    logic [15:0] sort_pos [KEEP_LIMIT];
    out_word_t   res;
    begin
      k = (keep_reg == 0) ? 1 : (keep_reg > KEEP_LIMIT) ? KEEP_LIMIT : int'(keep_reg);
      if (kept_n < k) begin
        kept_val[kept_n] = v;
        kept_pos[kept_n] = next_pos;
        kept_n++;
      end else if (kept_n > 0) begin
        // replace the largest held entry only by a strictly smaller value
        top = 0;
        for (i = 1; i < kept_n; i++)
          if (ranks_before(kept_val[top], kept_pos[top], kept_val[i], kept_pos[i]))
            top = i;
        if (rank_key(v) < rank_key(kept_val[top])) begin
          kept_val[top] = v;
          kept_pos[top] = next_pos;
        end
      end
      if (next_pos != 16'hFFFF)
        next_pos++;
      if (is_last) begin
        for (i = 0; i < kept_n; i++) begin
          j = i;
          while (j > 0 && ranks_before(kept_val[i], kept_pos[i],
                                       sort_val[j-1], sort_pos[j-1])) begin
            sort_val[j] = sort_val[j-1];
            sort_pos[j] = sort_pos[j-1];
            j--;
          end
          sort_val[j] = kept_val[i];
          sort_pos[j] = kept_pos[i];
        end
        n = (kept_n < k) ? kept_n : k;
        for (i = 0; i < n; i++) begin
          res.out_value = sort_val[i];
          res.out_index = sort_pos[i];
          res.out_last  = (i == n - 1);
          pending_results.push_back(res);
        end
        kept_n   = 0;
        next_pos = '0;
      end
    end
  endtask

  // Offer one word, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_word(input logic [31:0] v, input logic is_last);
    begin
      @(negedge clk);
      while (idle_on && $urandom_range(99) < 22) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
      in_valid         = 1'b1;
      in_data.in_value = v;
      in_data.in_last  = is_last;
      @(posedge clk);
      while (in_stall)
        @(posedge clk);
      select_accept(v, is_last);
    end
  endtask

  // Drop valid, drain all expected words, then let any item still in work finish
  task automatic settle();
    begin
      @(negedge clk);
      in_valid = 1'b0;
      while (pending_results.size() != 0)
        @(posedge clk);
      repeat (100) @(posedge clk);
    end
  endtask

  // Write one register; the mirror follows at the same edge
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    begin
      @(negedge clk);
      cfg_write = 1'b1;
      cfg_index = idx;
      cfg_data  = data;
      @(posedge clk);
      if (idx == REG_KEEP_COUNT)
        keep_reg = data;
      else
        signed_reg = data[0];
      @(negedge clk);
      cfg_write = 1'b0;
    end
  endtask

  // Mix of full-range values, tight clusters for ties, and sign-boundary values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom_range(15);
      1: return 32'h8000_0000 + $urandom_range(15) - 32'd8;
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_keep();
    case ($urandom_range(5))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      default: return 6'($urandom_range(16, 2));
    endcase
  endfunction

  // Send one stream of random values; optionally change a register halfway
  task automatic run_stream(input int len, input bit split);
    int i;
    begin
      for (i = 0; i < len; i++) begin
        if (split && i == len / 2) begin
          settle();
          if ($urandom_range(1))
            write_reg(REG_KEEP_COUNT, pick_keep());
          else
            write_reg(REG_SIGNED_VALUES, CFG_DATA_W'($urandom));
        end
        send_word(pick_value(), i == len - 1);
      end
    end
  endtask

  task automatic test_reset_defaults();
    begin
      // signed compare and keep of eight straight out of reset
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0001, 1'b1);
      settle();
    end
  endtask

  task automatic test_unsigned_ties();
    begin
      write_reg(REG_SIGNED_VALUES, 6'd0);
      write_reg(REG_KEEP_COUNT, 6'd3);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'd5, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'd5, 1'b0);
      send_word(32'd0, 1'b0);
      send_word(32'd5, 1'b1);
      settle();
    end
  endtask

  task automatic test_keep_limits();
    begin
      // zero acts as one
      write_reg(REG_KEEP_COUNT, 6'd0);
      send_word(32'd9, 1'b0);
      send_word(32'd4, 1'b0);
      send_word(32'd7, 1'b1);
      settle();
      // above the maximum acts as the maximum
      write_reg(REG_KEEP_COUNT, 6'd63);
      send_word(32'd3, 1'b0);
      send_word(32'd1, 1'b1);
      settle();
      // a stream of a single word
      write_reg(REG_KEEP_COUNT, 6'd1);
      send_word(32'h1234_5678, 1'b1);
      settle();
    end
  endtask

  task automatic test_midstream_changes();
    begin
      write_reg(REG_KEEP_COUNT, 6'd6);
      write_reg(REG_SIGNED_VALUES, 6'd1);
      send_word(32'd10, 1'b0);
      send_word(32'hFFFF_FFF0, 1'b0);
      send_word(32'd30, 1'b0);
      send_word(32'h8000_0001, 1'b0);
      send_word(32'd20, 1'b0);
      send_word(32'h7FFF_0000, 1'b0);
      // shrink the keep count while six entries are held
      settle();
      write_reg(REG_KEEP_COUNT, 6'd2);
      send_word(32'd15, 1'b0);
      // flip signedness before the closing word
      settle();
      write_reg(REG_SIGNED_VALUES, 6'd0);
      send_word(32'd25, 1'b1);
      settle();
    end
  endtask

  task automatic test_random_streams();
    int sent;
    int len;
    bit split;
    begin
      sent = 0;
      while (sent < 220) begin
        if ($urandom_range(99) < 40) begin
          settle();
          write_reg(REG_KEEP_COUNT, pick_keep());
          if ($urandom_range(1))
            write_reg(REG_SIGNED_VALUES, CFG_DATA_W'($urandom));
        end
        len   = ($urandom_range(99) < 75) ? $urandom_range(12, 1) : $urandom_range(45, 13);
        split = (len > 1) && ($urandom_range(99) < 15);
        run_stream(len, split);
        sent += len;
      end
      settle();
    end
  endtask

  task automatic test_back_to_back();
    int s;
    begin
      idle_on = 1'b0;
      write_reg(REG_KEEP_COUNT, 6'd5);
      for (s = 0; s < 4; s++)
        run_stream($urandom_range(12, 3), 1'b0);
      settle();
      idle_on = 1'b1;
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    begin
      write_reg(REG_KEEP_COUNT, 6'd32);
      for (i = 0; i < 39; i++)
        send_word(pick_value(), 1'b0);
      // block the result side for a long hold-off while the closing word's results back up
      hold_req = 1500;
      send_word(pick_value(), 1'b1);
      // keep offering the next stream while results back up
      run_stream(10, 1'b0);
      settle();
    end
  endtask

  // Result side: long hold-off on request, random stalls otherwise while idle_on is set
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_stall = 1'b1;
        hold_req--;
      end else begin
        out_stall = idle_on && ($urandom_range(99) < 22);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word value=%h index=%0d last=%b", $time,
                 out_data.out_value, out_data.out_index, out_data.out_last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_value !== want.out_value) begin
          $display("%0t: out_value expected %h actual %h", $time,
                   want.out_value, out_data.out_value);
          errors++;
        end
        if (out_data.out_index !== want.out_index) begin
          $display("%0t: out_index expected %0d actual %0d", $time,
                   want.out_index, out_data.out_index);
          errors++;
        end
        if (out_data.out_last !== want.out_last) begin
          $display("%0t: out_last expected %b actual %b", $time,
                   want.out_last, out_data.out_last);
          errors++;
        end
      end
    end
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_KEEP_COUNT;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_unsigned_ties();
    test_keep_limits();
    test_midstream_changes();
    test_random_streams();
    test_back_to_back();
    test_output_backpressure();

    settle();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
